// ===== rtl/stb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg: shared types and codes for the sorted table
// Opcodes, status codes, channel payloads and cell control structs.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_REMOVE_VAL = 3'd1;
    localparam logic [2:0] OP_FIND       = 3'd2;
    localparam logic [2:0] OP_READ_POS   = 3'd3;
    localparam logic [2:0] OP_REMOVE_POS = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [7:0]         position;
    } stb_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [4:0]         where;
        logic signed [31:0] entry_value;
        logic [4:0]         count;
    } stb_rsp_t;

    typedef struct packed {
        logic ins;
        logic del_val;
        logic del_pos;
    } stb_cmd_t;

    typedef struct packed {
        logic gtv;
        logic stop;
        logic hit;
    } stb_flag_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } stb_state_t;

endpackage

// ===== rtl/stb_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_chan: valid/ready channel
// One transfer per rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface stb_chan #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/sorted_table_insert_remove_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_find: descending sorted table
// Row of DEPTH cells kept largest first with insert, remove, find, read,
// remove at position and clear.
// ----------------------------------------------------------------------------
// Every operation returns one transfer: when a request is accepted each cell
// registers its compare against the request value; in the execute state the
// block locates the stop position across the row, shifts the cells and loads
// the response register. A new request is taken while a response waits to
// be taken; the block stalls in its execute state only when the response
// register is still full. Entries are undefined after reset; only the first
// count entries are ever read.
module sorted_table_insert_remove_find #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    stb_chan.sink    req,
    stb_chan.source  rsp
);
    import stb_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH + 2);
    localparam int EW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    stb_state_t             state_reg;
    stb_state_t             state_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [2:0]             op_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [7:0]             pos_reg;
    stb_rsp_t               out_reg;
    stb_rsp_t               out_next;
    logic                   out_vld_reg;

    logic                   load;
    logic                   fire;
    logic [EW-1:0]          req_ext;
    logic [VALUE_WIDTH-1:0] cmp_val;
    logic                   full;
    logic                   pos_ok;
    logic                   match;
    logic [PW-1:0]          stop_pos;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic [EW-1:0]          rd_ext;
    stb_cmd_t               cmd;

    logic [VALUE_WIDTH-1:0] entry [DEPTH];
    logic [VALUE_WIDTH-1:0] rd    [DEPTH];
    stb_flag_t              flag  [DEPTH];

    assign req.ready = (state_reg == S_IDLE);
    assign load      = req.valid && req.ready;
    assign fire      = (state_reg == S_EXEC) && (!out_vld_reg || rsp.ready);

    assign req_ext = EW'($unsigned(req.payload.value));
    assign cmp_val = req_ext[VALUE_WIDTH-1:0];

    assign full   = (count_reg == CW'(DEPTH));
    assign pos_ok = (pos_reg != 8'd0) && ({1'b0, pos_reg} <= 9'(count_reg));

    assign cmd.ins     = fire && (op_reg == OP_INSERT) && !full;
    assign cmd.del_val = fire && (op_reg == OP_REMOVE_VAL) && match;
    assign cmd.del_pos = fire && (op_reg == OP_REMOVE_POS) && pos_ok;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                   lgtv;
        logic [VALUE_WIDTH-1:0] lent;
        logic [VALUE_WIDTH-1:0] rent;

        if (i == 0)
        begin : g_first
            assign lgtv = 1'b1;
            assign lent = val_reg;
        end
        else
        begin : g_mid
            assign lgtv = flag[i-1].gtv;
            assign lent = entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rent = entry[i];
        end
        else
        begin : g_inner
            assign rent = entry[i+1];
        end

        stb_cell #(
            .IDX (i),
            .VW  (VALUE_WIDTH),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .load        (load),
            .cmp_val     (cmp_val),
            .count       (count_reg),
            .ins_val     (val_reg),
            .pos         (pos_reg),
            .cmd         (cmd),
            .left_gtv    (lgtv),
            .left_entry  (lent),
            .right_entry (rent),
            .entry       (entry[i]),
            .flag        (flag[i]),
            .rd          (rd[i])
        );
    end

    // stop position is one-hot across the row; past the end when all are larger
    always_comb
    begin
        stop_pos = '0;
        match    = 1'b0;
        rd_val   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (flag[i].stop)
            begin
                stop_pos = stop_pos | PW'(i + 1);
            end
            match  = match | flag[i].hit;
            rd_val = rd_val | rd[i];
        end
        if (flag[DEPTH-1].gtv)
        begin
            stop_pos = stop_pos | PW'(DEPTH + 1);
        end
    end

    assign rd_ext = EW'($signed(rd_val));

    always_comb
    begin
        count_next           = count_reg;
        out_next.status      = ST_OK;
        out_next.found       = 1'b0;
        out_next.where       = 5'd0;
        out_next.entry_value = '0;
        case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    out_next.status = ST_FULL;
                end
                else
                begin
                    count_next     = count_reg + 1'b1;
                    out_next.where = 5'(stop_pos);
                end
            end
            OP_REMOVE_VAL:
            begin
                if (match)
                begin
                    count_next     = count_reg - 1'b1;
                    out_next.found = 1'b1;
                    out_next.where = 5'(stop_pos);
                end
                else
                begin
                    out_next.status = ST_NOT_FOUND;
                end
            end
            OP_FIND:
            begin
                out_next.found  = match;
                out_next.status = match ? ST_OK : ST_NOT_FOUND;
                out_next.where  = 5'(stop_pos);
            end
            OP_READ_POS:
            begin
                if (pos_ok)
                begin
                    out_next.entry_value = rd_ext[31:0];
                    out_next.where       = 5'(pos_reg);
                end
                else
                begin
                    out_next.status = ST_RANGE;
                end
            end
            OP_REMOVE_POS:
            begin
                if (pos_ok)
                begin
                    count_next     = count_reg - 1'b1;
                    out_next.where = 5'(pos_reg);
                end
                else
                begin
                    out_next.status = ST_RANGE;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        out_next.count = 5'(count_next);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                count_reg   <= count_next;
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg  <= req.payload.opcode;
            val_reg <= cmp_val;
            pos_reg <= req.payload.position;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid   = out_vld_reg;
    assign rsp.payload = out_reg;

endmodule

// ===== rtl/stb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_cell: one slot of the sorted table
// Holds one entry, registers its compare against the search value and
// shifts left or right with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module stb_cell #(
    parameter int IDX = 0,
    parameter int VW  = 32,
    parameter int CW  = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [VW-1:0]       cmp_val,
    input  logic [CW-1:0]       count,
    input  logic [VW-1:0]       ins_val,
    input  logic [7:0]          pos,
    input  stb_pkg::stb_cmd_t   cmd,
    input  logic                left_gtv,
    input  logic [VW-1:0]       left_entry,
    input  logic [VW-1:0]       right_entry,
    output logic [VW-1:0]       entry,
    output stb_pkg::stb_flag_t  flag,
    output logic [VW-1:0]       rd
);
    import stb_pkg::*;

    localparam logic [8:0] POS1 = 9'(IDX + 1);

    logic [VW-1:0] entry_reg;
    logic [VW-1:0] entry_next;
    logic          gt_reg;
    logic          eq_reg;
    logic          vld_reg;
    logic          gtv;
    logic          sel;
    logic          at_or_after;

    assign gtv         = vld_reg && gt_reg;
    assign sel         = ({1'b0, pos} == POS1);
    assign at_or_after = ({1'b0, pos} <= POS1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            gt_reg  <= ($signed(entry_reg) > $signed(cmp_val));
            eq_reg  <= (entry_reg == cmp_val);
            vld_reg <= (count > CW'(IDX));
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !gtv)
        begin
            entry_next = left_gtv ? ins_val : left_entry;
        end
        else if (cmd.del_val && !gtv)
        begin
            entry_next = right_entry;
        end
        else if (cmd.del_pos && at_or_after)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    assign flag.gtv  = gtv;
    assign flag.stop = left_gtv && !gtv;
    assign flag.hit  = left_gtv && !gtv && vld_reg && eq_reg;
    assign rd        = sel ? entry_reg : '0;

endmodule

// ===== dv/tb_sorted_table_insert_remove_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_remove_find: self-checking bench for the sorted table
// Drives insert, remove, find, read, remove-at-position and clear requests
// over the request channel with random gaps and back-pressure. A behavioral
// copy of the descending table predicts every response. Each response is
// checked field by field, in order, against the predicted stream.
// ----------------------------------------------------------------------------
module tb_sorted_table_insert_remove_find;
    import stb_pkg::*;

    localparam int          DEPTH       = 16;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [2:0]  OP_SPARE_6  = 3'd6;
    localparam logic [2:0]  OP_SPARE_7  = 3'd7;
    localparam logic signed [31:0] V_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] V_MIN = 32'sh8000_0000;

    logic clk;
    logic rst_n;

    stb_chan #(.payload_t(stb_req_t)) req_if ();
    stb_chan #(.payload_t(stb_rsp_t)) rsp_if ();

    sorted_table_insert_remove_find u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic signed [31:0] rows[$];
    stb_rsp_t           pending_rsp_q[$];
    int                 src_idle_pct;
    int                 snk_idle_pct;
    int                 err_cnt;
    int                 rsp_checked;
    int                 full_hits;
    int                 op_seen[8];
    int unsigned        cyc;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT)
        begin
            $display("[sorted_table_insert_remove_find] ERROR");
            $finish;
        end
    end

    function automatic stb_req_t mk_req(logic [2:0] op, logic signed [31:0] v,
                                        logic [7:0] pos);
        stb_req_t r;
        r.opcode   = op;
        r.value    = v;
        r.position = pos;
        return r;
    endfunction

    // Descending table: search moves on while the value is below the entry.
    function automatic stb_rsp_t predict_table_op(stb_req_t r);
        stb_rsp_t           o;
        logic signed [31:0] v;
        int                 stop;
        int                 pos;
        bit                 hit;
        o    = '0;
        v    = r.value;
        pos  = r.position;
        stop = 1;
        while (stop <= rows.size() && v < rows[stop - 1])
            stop++;
        hit = (stop <= rows.size()) && (rows[stop - 1] == v);
        case (r.opcode)
            OP_INSERT:
            begin
                if (rows.size() >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    rows.insert(stop - 1, v);
                    o.where = 5'(stop);
                end
            end
            OP_REMOVE_VAL:
            begin
                if (hit)
                begin
                    rows.delete(stop - 1);
                    o.found = 1'b1;
                    o.where = 5'(stop);
                end
                else
                    o.status = ST_NOT_FOUND;
            end
            OP_FIND:
            begin
                o.where = 5'(stop);
                if (hit)
                    o.found = 1'b1;
                else
                    o.status = ST_NOT_FOUND;
            end
            OP_READ_POS:
            begin
                if (pos >= 1 && pos <= rows.size())
                begin
                    o.entry_value = rows[pos - 1];
                    o.where       = 5'(pos);
                end
                else
                    o.status = ST_RANGE;
            end
            OP_REMOVE_POS:
            begin
                if (pos >= 1 && pos <= rows.size())
                begin
                    rows.delete(pos - 1);
                    o.where = 5'(pos);
                end
                else
                    o.status = ST_RANGE;
            end
            OP_CLEAR:
                rows.delete();
            default:
                ;
        endcase
        o.count = 5'(rows.size());
        return o;
    endfunction

    function automatic logic signed [31:0] rand_value();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0, 1, 2:
                v = (rows.size() > 0) ? rows[$urandom_range(rows.size() - 1)]
                                      : $signed($urandom_range(16)) - 8;
            3, 4, 5:
                v = $signed($urandom_range(16)) - 8;
            6:
            begin
                case ($urandom_range(5))
                    0: v = V_MAX;
                    1: v = V_MIN;
                    2: v = 0;
                    3: v = -1;
                    4: v = V_MAX - 1;
                    default: v = V_MIN + 1;
                endcase
            end
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rand_position();
        if ($urandom_range(99) < 80)
            return 8'($urandom_range(rows.size() + 1));
        return 8'($urandom_range(255));
    endfunction

    // One request transfer; prediction is taken at the accepting edge.
    task automatic send_op(stb_req_t item);
        stb_rsp_t exp_rsp;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        do
            @(posedge clk);
        while (!req_if.ready);
        exp_rsp = predict_table_op(item);
        if (exp_rsp.status == ST_FULL)
            full_hits++;
        op_seen[item.opcode]++;
        pending_rsp_q.push_back(exp_rsp);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp_q.size() != 0);
    endtask

    always @(posedge clk)
    begin
        stb_rsp_t got;
        stb_rsp_t exp_rsp;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.payload;
                if (pending_rsp_q.size() == 0)
                begin
                    $error("response transfer with nothing expected");
                    err_cnt++;
                end
                else
                begin
                    exp_rsp = pending_rsp_q.pop_front();
                    rsp_checked++;
                    if (got.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
                        err_cnt++;
                    end
                    if (got.found !== exp_rsp.found)
                    begin
                        $error("found: expected %0d, got %0d", exp_rsp.found, got.found);
                        err_cnt++;
                    end
                    if (got.where !== exp_rsp.where)
                    begin
                        $error("where: expected %0d, got %0d", exp_rsp.where, got.where);
                        err_cnt++;
                    end
                    if (got.entry_value !== exp_rsp.entry_value)
                    begin
                        $error("entry_value: expected %0d, got %0d",
                               exp_rsp.entry_value, got.entry_value);
                        err_cnt++;
                    end
                    if (got.count !== exp_rsp.count)
                    begin
                        $error("count: expected %0d, got %0d", exp_rsp.count, got.count);
                        err_cnt++;
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic test_directed();
        send_op(mk_req(OP_FIND, 5, 0));
        send_op(mk_req(OP_READ_POS, 0, 1));
        send_op(mk_req(OP_REMOVE_VAL, 5, 0));
        send_op(mk_req(OP_REMOVE_POS, 0, 0));
        send_op(mk_req(OP_INSERT, V_MAX, 0));
        send_op(mk_req(OP_INSERT, V_MIN, 0));
        send_op(mk_req(OP_INSERT, 0, 0));
        send_op(mk_req(OP_INSERT, -1, 0));
        send_op(mk_req(OP_INSERT, 0, 0));
        send_op(mk_req(OP_FIND, 0, 0));
        send_op(mk_req(OP_FIND, 5, 0));
        send_op(mk_req(OP_FIND, V_MIN, 0));
        send_op(mk_req(OP_FIND, V_MAX, 0));
        send_op(mk_req(OP_READ_POS, 0, 0));
        send_op(mk_req(OP_READ_POS, 0, 5));
        send_op(mk_req(OP_READ_POS, 0, 6));
        send_op(mk_req(OP_READ_POS, 0, 8'hff));
        send_op(mk_req(OP_REMOVE_VAL, 0, 0));
        send_op(mk_req(OP_REMOVE_VAL, 7, 0));
        send_op(mk_req(OP_REMOVE_POS, 0, 1));
        send_op(mk_req(OP_REMOVE_POS, 0, 4));
        send_op(mk_req(OP_SPARE_6, V_MIN, 8'hff));
        send_op(mk_req(OP_SPARE_7, -1, 8'h01));
        send_op(mk_req(OP_CLEAR, 0, 0));
        send_op(mk_req(OP_FIND, V_MIN, 0));
    endtask

    task automatic test_full_table();
        while (rows.size() < DEPTH)
            send_op(mk_req(OP_INSERT, rand_value(), 0));
        send_op(mk_req(OP_INSERT, rand_value(), 0));
        send_op(mk_req(OP_FIND, V_MIN, 0));
        send_op(mk_req(OP_READ_POS, 0, 8'(DEPTH)));
        send_op(mk_req(OP_READ_POS, 0, 8'(DEPTH + 1)));
        send_op(mk_req(OP_REMOVE_POS, 0, 8'(DEPTH)));
        send_op(mk_req(OP_INSERT, V_MIN, 0));
        send_op(mk_req(OP_INSERT, V_MAX, 0));
        send_op(mk_req(OP_REMOVE_VAL, V_MIN, 0));
    endtask

    task automatic test_random_mix(int n_ops);
        stb_req_t item;
        int       sel;
        repeat (n_ops)
        begin
            sel  = $urandom_range(99);
            item = mk_req(OP_INSERT, rand_value(), rand_position());
            if (sel < 42)
                item.opcode = OP_INSERT;
            else if (sel < 54)
                item.opcode = OP_REMOVE_VAL;
            else if (sel < 68)
                item.opcode = OP_FIND;
            else if (sel < 80)
                item.opcode = OP_READ_POS;
            else if (sel < 90)
                item.opcode = OP_REMOVE_POS;
            else if (sel < 92)
                item.opcode = OP_CLEAR;
            else if (sel < 94)
            begin
                item.opcode   = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
                item.value    = $urandom;
                item.position = 8'($urandom);
            end
            else
                item.opcode = OP_INSERT;
            send_op(item);
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        err_cnt        = 0;
        rsp_checked    = 0;
        full_hits      = 0;
        src_idle_pct   = 10;
        snk_idle_pct   = 46;
        foreach (op_seen[i])
            op_seen[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drained();
        test_full_table();
        test_random_mix(600);
        wait_drained();

        src_idle_pct = 46;
        snk_idle_pct = 10;
        test_full_table();
        test_random_mix(600);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_mix(620);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Ops sent: ins %0d rm-val %0d find %0d read %0d rm-pos %0d clr %0d spare %0d",
                 op_seen[OP_INSERT], op_seen[OP_REMOVE_VAL], op_seen[OP_FIND],
                 op_seen[OP_READ_POS], op_seen[OP_REMOVE_POS], op_seen[OP_CLEAR],
                 op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7]);
        $display("Responses checked: %0d, inserts refused on a full table: %0d",
                 rsp_checked, full_hits);
        if (err_cnt == 0 && pending_rsp_q.size() == 0)
            $display("[sorted_table_insert_remove_find] OK");
        else
            $display("[sorted_table_insert_remove_find] ERROR");
        $finish;
    end

endmodule
